FILE: hw/rtl/block_buffer_pool_manager_assert.svh
// assertion macros for the buffer pool manager
`ifndef BLOCK_BUFFER_POOL_MANAGER_ASSERT_SVH
`define BLOCK_BUFFER_POOL_MANAGER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BBPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BBPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bbpm_pkg.sv
// shared types and codes for the buffer pool manager
package bbpm_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam logic [1:0] KIND_GET     = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_PIN     = 2'd2;
  localparam logic [1:0] KIND_FLUSH   = 2'd3;

  localparam logic [2:0] STAT_HIT      = 3'd0;
  localparam logic [2:0] STAT_FREE     = 3'd1;
  localparam logic [2:0] STAT_CLEAN    = 3'd2;
  localparam logic [2:0] STAT_DIRTY    = 3'd3;
  localparam logic [2:0] STAT_NONE     = 3'd4;
  localparam logic [2:0] STAT_FLUSHED  = 3'd5;
  localparam logic [2:0] STAT_NOFLUSH  = 3'd6;
  localparam logic [2:0] STAT_COUNT    = 3'd7;

  localparam logic [7:0] REFS_MAX = 8'hFF;

  typedef struct packed {
    logic        dirty;
    logic [7:0]  refs;
    logic [31:0] block;
    logic [7:0]  file;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } rd_t;

  typedef struct packed {
    logic   en;
    logic   set_valid;
    entry_t ent;
  } wr_t;

endpackage

FILE: hw/rtl/bbpm_store.sv
// slot tag store: entry memory with valid and written bits per slot
module bbpm_store #(
  parameter int SLOTS = bbpm_pkg::SLOTS_DEFAULT,
  parameter int IW    = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IW-1:0]    rd_addr,
  output bbpm_pkg::rd_t    rd,
  input  logic [IW-1:0]    wr_addr,
  input  bbpm_pkg::wr_t    wr
);

  bbpm_pkg::entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] init_r;
  bbpm_pkg::entry_t q_r;
  logic             q_valid_r;
  logic             q_init_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.ent;
    end
    q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      init_r    <= '0;
      q_valid_r <= 1'b0;
      q_init_r  <= 1'b0;
    end else begin
      q_valid_r <= valid_r[rd_addr];
      q_init_r  <= init_r[rd_addr];
      if (wr.en) begin
        init_r[wr_addr] <= 1'b1;
        if (wr.set_valid) begin
          valid_r[wr_addr] <= 1'b1;
        end
      end
    end
  end

  // a slot never written reads as all zero
  always_comb begin
    rd.valid = q_valid_r;
    rd.ent   = q_init_r ? q_r : '0;
  end

endmodule

FILE: hw/rtl/block_buffer_pool_manager.sv
// Buffer pool manager top level: request sequencer around the slot tag store.
// One request enters on the in_ channel (kind in in_tuser, operands in
// in_tdata) and exactly one response leaves on the out_ channel (status in
// out_tuser, slot and writeback details in out_tdata).
// A get request scans every slot once through the single read port of the
// tag store, one slot per cycle, tracking hit, free, clean and dirty victims
// with one compare unit; the response is registered after the scan, and the
// next request is taken once the response register has been loaded.
// Release, pin and flush read one slot and go straight to the final step; the
// scan over the store's read port is what makes a get request take longer.
// in_tready is high only while no request is in progress.
// The response sits in an output register; if the receiver stalls, the
// sequencer waits in its final step with nothing written until the register
// frees, and no request is taken meanwhile.
// Reset clears all valid and written bits at once, so every reference count
// reads as zero; the block is ready in the first cycle after reset.
`include "block_buffer_pool_manager_assert.svh"

module block_buffer_pool_manager #(
  parameter int SLOTS = bbpm_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // file_id, block_num, file_blocks, slot
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // slot_out, read_needed, zero_fill, writeback,
                                  // wb_file, wb_block, count_error
  output logic [2:0]  out_tuser   // status
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LastCnt = CW'(SLOTS);
  localparam logic [8:0] SlotsW = 9'(SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  file_r;
  logic [31:0] blk_r;
  logic [31:0] nblk_r;
  logic [3:0]  slot_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          hit_f_r, hit_f_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [7:0]    hit_refs_r, hit_refs_nxt;
  logic          hit_dirty_r, hit_dirty_nxt;
  logic          free_f_r, free_f_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          cln_f_r, cln_f_nxt;
  logic [IW-1:0] cln_idx_r, cln_idx_nxt;
  logic          drt_f_r, drt_f_nxt;
  logic [IW-1:0] drt_idx_r, drt_idx_nxt;
  logic [7:0]    drt_file_r, drt_file_nxt;
  logic [31:0]   drt_blk_r, drt_blk_nxt;

  logic          out_valid_r;
  logic [47:0]   out_data_r, out_data_nxt;
  logic [2:0]    out_user_r, out_user_nxt;

  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  bbpm_pkg::rd_t rd;
  bbpm_pkg::wr_t wr;

  logic          in_acc;
  logic          out_free;
  logic          in_pool;
  logic [IW-1:0] ev_idx;
  logic          match;
  logic [7:0]    add_base;
  logic          add_dec;
  logic [7:0]    add_sum;
  logic          fresh;

  logic [2:0]    r_status;
  logic [3:0]    r_slot;
  logic          r_read;
  logic          r_zero;
  logic          r_wb;
  logic [7:0]    r_wb_file;
  logic [31:0]   r_wb_blk;
  logic          r_err;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign in_pool = ({5'd0, slot_r} < SlotsW);
  assign ev_idx  = IW'(cnt_r - 1'b1);
  assign match   = rd.valid && (rd.ent.file == file_r) && (rd.ent.block == blk_r);
  assign fresh   = !(blk_r < nblk_r);

  // shared count unit: increment for hit and pin, decrement for release
  assign add_sum = add_base + (add_dec ? 8'hFF : 8'h01);

  always_comb begin
    unique case (state_r)
      ST_IDLE: rd_addr = IW'(in_tdata[75:72]);
      ST_SCAN: rd_addr = (cnt_r < LastCnt) ? IW'(cnt_r) : '0;
      default: rd_addr = IW'(slot_r);
    endcase
  end

  bbpm_store #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd      (rd),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  // scan evaluation and sequencing
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hit_f_nxt     = hit_f_r;
    hit_idx_nxt   = hit_idx_r;
    hit_refs_nxt  = hit_refs_r;
    hit_dirty_nxt = hit_dirty_r;
    free_f_nxt    = free_f_r;
    free_idx_nxt  = free_idx_r;
    cln_f_nxt     = cln_f_r;
    cln_idx_nxt   = cln_idx_r;
    drt_f_nxt     = drt_f_r;
    drt_idx_nxt   = drt_idx_r;
    drt_file_nxt  = drt_file_r;
    drt_blk_nxt   = drt_blk_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt    = '0;
          hit_f_nxt  = 1'b0;
          free_f_nxt = 1'b0;
          cln_f_nxt  = 1'b0;
          drt_f_nxt  = 1'b0;
          state_nxt  = (in_tuser == bbpm_pkg::KIND_GET) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          if (match && !hit_f_r) begin
            hit_f_nxt     = 1'b1;
            hit_idx_nxt   = ev_idx;
            hit_refs_nxt  = rd.ent.refs;
            hit_dirty_nxt = rd.ent.dirty;
          end
          if (!rd.valid && !free_f_r) begin
            free_f_nxt   = 1'b1;
            free_idx_nxt = ev_idx;
          end
          if ((rd.ent.refs == 8'd0) && !rd.ent.dirty && !cln_f_r) begin
            cln_f_nxt   = 1'b1;
            cln_idx_nxt = ev_idx;
          end
          if ((rd.ent.refs == 8'd0) && rd.ent.dirty && !drt_f_r) begin
            drt_f_nxt    = 1'b1;
            drt_idx_nxt  = ev_idx;
            drt_file_nxt = rd.ent.file;
            drt_blk_nxt  = rd.ent.block;
          end
        end
        if (cnt_r == LastCnt) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // response and store update
  always_comb begin
    r_status  = bbpm_pkg::STAT_NONE;
    r_slot    = '0;
    r_read    = 1'b0;
    r_zero    = 1'b0;
    r_wb      = 1'b0;
    r_wb_file = '0;
    r_wb_blk  = '0;
    r_err     = 1'b0;
    add_base  = rd.ent.refs;
    add_dec   = 1'b0;
    wr_addr   = IW'(slot_r);
    wr        = '0;
    wr.ent    = rd.ent;
    unique case (kind_r)
      bbpm_pkg::KIND_GET: begin
        wr.ent.file  = file_r;
        wr.ent.block = blk_r;
        wr.ent.refs  = 8'd1;
        wr.ent.dirty = fresh;
        wr.set_valid = 1'b1;
        add_base     = hit_refs_r;
        if (hit_f_r) begin
          r_status     = bbpm_pkg::STAT_HIT;
          r_slot       = 4'(hit_idx_r);
          r_err        = (hit_refs_r == bbpm_pkg::REFS_MAX);
          wr_addr      = hit_idx_r;
          wr.en        = !r_err;
          wr.ent.refs  = add_sum;
          wr.ent.dirty = hit_dirty_r;
        end else if (free_f_r || cln_f_r || drt_f_r) begin
          wr.en  = 1'b1;
          r_read = !fresh;
          r_zero = fresh;
          if (free_f_r) begin
            r_status = bbpm_pkg::STAT_FREE;
            wr_addr  = free_idx_r;
          end else if (cln_f_r) begin
            r_status = bbpm_pkg::STAT_CLEAN;
            wr_addr  = cln_idx_r;
          end else begin
            r_status  = bbpm_pkg::STAT_DIRTY;
            wr_addr   = drt_idx_r;
            r_wb      = 1'b1;
            r_wb_file = drt_file_r;
            r_wb_blk  = drt_blk_r;
          end
          r_slot = 4'(wr_addr);
        end
      end
      bbpm_pkg::KIND_FLUSH: begin
        r_slot = slot_r;
        if (in_pool && rd.ent.dirty) begin
          r_status     = bbpm_pkg::STAT_FLUSHED;
          r_wb         = 1'b1;
          r_wb_file    = rd.ent.file;
          r_wb_blk     = rd.ent.block;
          wr.en        = 1'b1;
          wr.ent.dirty = 1'b0;
        end else begin
          r_status = bbpm_pkg::STAT_NOFLUSH;
        end
      end
      default: begin
        r_status    = bbpm_pkg::STAT_COUNT;
        r_slot      = slot_r;
        add_dec     = (kind_r == bbpm_pkg::KIND_RELEASE);
        wr.ent.refs = add_sum;
        if (!in_pool) begin
          r_err = 1'b1;
        end else if (add_dec) begin
          r_err = (rd.ent.refs == 8'd0);
        end else begin
          r_err = (rd.ent.refs == bbpm_pkg::REFS_MAX);
        end
        wr.en = !r_err;
      end
    endcase
    if (!(state_r == ST_DONE && out_free)) begin
      wr.en = 1'b0;
    end
    out_data_nxt = {r_err, r_wb_blk, r_wb_file, r_wb, r_zero, r_read, r_slot};
    out_user_nxt = r_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      hit_f_r     <= 1'b0;
      free_f_r    <= 1'b0;
      cln_f_r     <= 1'b0;
      drt_f_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      hit_f_r  <= hit_f_nxt;
      free_f_r <= free_f_nxt;
      cln_f_r  <= cln_f_nxt;
      drt_f_r  <= drt_f_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_tuser;
      file_r <= in_tdata[7:0];
      blk_r  <= in_tdata[39:8];
      nblk_r <= in_tdata[71:40];
      slot_r <= in_tdata[75:72];
    end
    hit_idx_r   <= hit_idx_nxt;
    hit_refs_r  <= hit_refs_nxt;
    hit_dirty_r <= hit_dirty_nxt;
    free_idx_r  <= free_idx_nxt;
    cln_idx_r   <= cln_idx_nxt;
    drt_idx_r   <= drt_idx_nxt;
    drt_file_r  <= drt_file_nxt;
    drt_blk_r   <= drt_blk_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  `BBPM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready, "ready right after accept")
  `BBPM_ASSERT_IMP(a_wb_status, clk, rst_n, out_valid_r && out_data_r[6], (out_user_r == bbpm_pkg::STAT_DIRTY) || (out_user_r == bbpm_pkg::STAT_FLUSHED), "writeback with wrong status")
  `BBPM_ASSERT_IMP(a_read_zero, clk, rst_n, out_valid_r, !(out_data_r[4] && out_data_r[5]), "read and zero fill together")
  `BBPM_ASSERT_IMP(a_write_done, clk, rst_n, wr.en, state_r == ST_DONE, "store write outside final step")

endmodule

FILE: verif/tb.sv
// testbench for block_buffer_pool_manager: directed and random requests against a slot predictor
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS = bbpm_pkg::SLOTS_DEFAULT;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = SLOTS + 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  file_id;
    logic [31:0] block_num;
    logic [31:0] file_blocks;
    logic [3:0]  slot;
  } pool_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_out;
    logic        read_needed;
    logic        zero_fill;
    logic        writeback;
    logic [7:0]  wb_file;
    logic [31:0] wb_block;
    logic        count_error;
  } pool_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // file_id, block_num, file_blocks, slot
  logic [1:0]  in_tuser = '0;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // slot_out, read_needed, zero_fill, writeback,
                                // wb_file, wb_block, count_error
  logic [2:0]  out_tuser;       // status

  logic        pool_valid [SLOTS];
  logic [7:0]  pool_file  [SLOTS];
  logic [31:0] pool_block [SLOTS];
  logic [7:0]  pool_refs  [SLOTS];
  logic        pool_dirty [SLOTS];

  pool_resp_t pending_responses [$];
  int fail_count = 0;
  int stall_cycles = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 59;

  block_buffer_pool_manager #(.SLOTS(SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one request to the slot table and returns the response it calls for
  function automatic pool_resp_t pool_update(input pool_req_t r);
    pool_resp_t rsp;
    int idx;
    bit found;
    bit fresh;
    rsp = '0;
    idx = 0;
    found = 1'b0;
    case (r.kind)
      bbpm_pkg::KIND_GET: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && pool_valid[i] && pool_file[i] == r.file_id &&
              pool_block[i] == r.block_num) begin
            found = 1'b1;
            idx = i;
          end
        end
        if (found) begin
          rsp.status = bbpm_pkg::STAT_HIT;
          rsp.slot_out = idx[3:0];
          if (pool_refs[idx] < bbpm_pkg::REFS_MAX) pool_refs[idx]++;
          else rsp.count_error = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !pool_valid[i]) begin
              found = 1'b1;
              idx = i;
              rsp.status = bbpm_pkg::STAT_FREE;
            end
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && pool_refs[i] == 0 && !pool_dirty[i]) begin
              found = 1'b1;
              idx = i;
              rsp.status = bbpm_pkg::STAT_CLEAN;
            end
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && pool_refs[i] == 0 && pool_dirty[i]) begin
              found = 1'b1;
              idx = i;
              rsp.status = bbpm_pkg::STAT_DIRTY;
              rsp.writeback = 1'b1;
              rsp.wb_file = pool_file[i];
              rsp.wb_block = pool_block[i];
            end
          end
          if (found) begin
            fresh = !(r.block_num < r.file_blocks);
            pool_valid[idx] = 1'b1;
            pool_file[idx] = r.file_id;
            pool_block[idx] = r.block_num;
            pool_refs[idx] = 8'd1;
            pool_dirty[idx] = fresh;
            rsp.slot_out = idx[3:0];
            rsp.read_needed = !fresh;
            rsp.zero_fill = fresh;
          end else begin
            rsp.status = bbpm_pkg::STAT_NONE;
          end
        end
      end
      bbpm_pkg::KIND_FLUSH: begin
        rsp.slot_out = r.slot;
        if (int'(r.slot) < SLOTS && pool_dirty[r.slot]) begin
          rsp.status = bbpm_pkg::STAT_FLUSHED;
          rsp.writeback = 1'b1;
          rsp.wb_file = pool_file[r.slot];
          rsp.wb_block = pool_block[r.slot];
          pool_dirty[r.slot] = 1'b0;
        end else begin
          rsp.status = bbpm_pkg::STAT_NOFLUSH;
        end
      end
      default: begin
        rsp.status = bbpm_pkg::STAT_COUNT;
        rsp.slot_out = r.slot;
        if (int'(r.slot) >= SLOTS) begin
          rsp.count_error = 1'b1;
        end else if (r.kind == bbpm_pkg::KIND_RELEASE) begin
          if (pool_refs[r.slot] > 0) pool_refs[r.slot]--;
          else rsp.count_error = 1'b1;
        end else begin
          if (pool_refs[r.slot] < bbpm_pkg::REFS_MAX) pool_refs[r.slot]++;
          else rsp.count_error = 1'b1;
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic pool_req_t req_of(input logic [1:0] kind, input logic [7:0] file_id,
                                       input logic [31:0] block_num,
                                       input logic [31:0] file_blocks, input logic [3:0] slot);
    pool_req_t r;
    r.kind = kind;
    r.file_id = file_id;
    r.block_num = block_num;
    r.file_blocks = file_blocks;
    r.slot = slot;
    return r;
  endfunction

  task automatic send_request(input pool_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {4'b0, r.slot, r.file_blocks, r.block_num, r.file_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_responses.push_back(pool_update(r));
    @(negedge clk);
  endtask

  task automatic test_fill_and_evict();
    logic [31:0] blk;
    // touch invalid slots first so a free slot carries a count
    send_request(req_of(bbpm_pkg::KIND_PIN, 8'h00, 32'h0, 32'h0, 4'hF));
    send_request(req_of(bbpm_pkg::KIND_RELEASE, 8'h00, 32'h0, 32'h0, 4'hE));
    for (int i = 0; i < SLOTS; i++) begin
      blk = 32'(i) * 32'h0101_0101 + 32'h10;
      case (i)
        0: send_request(req_of(bbpm_pkg::KIND_GET, 8'h00, 32'h0, 32'h0, 4'h0));
        1: send_request(req_of(bbpm_pkg::KIND_GET, 8'hFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 4'hF));
        default: send_request(req_of(bbpm_pkg::KIND_GET, 8'(i * 29), blk,
                                     i[0] ? blk : blk + 32'd1, 4'(i)));
      endcase
    end
    send_request(req_of(bbpm_pkg::KIND_GET, 8'h11, 32'h8000_0000, 32'hFFFF_FFFF, 4'h0));
    send_request(req_of(bbpm_pkg::KIND_GET, pool_file[3], pool_block[3], 32'h0, 4'h0));
    send_request(req_of(bbpm_pkg::KIND_FLUSH, 8'h00, 32'h0, 32'h0, 4'd1));
    send_request(req_of(bbpm_pkg::KIND_FLUSH, 8'h00, 32'h0, 32'h0, 4'd1));
    send_request(req_of(bbpm_pkg::KIND_FLUSH, 8'h00, 32'h0, 32'h0, 4'd2));
    send_request(req_of(bbpm_pkg::KIND_RELEASE, 8'h00, 32'h0, 32'h0, 4'd2));
    send_request(req_of(bbpm_pkg::KIND_RELEASE, 8'h00, 32'h0, 32'h0, 4'd2));
    send_request(req_of(bbpm_pkg::KIND_GET, 8'h22, 32'h0000_7777, 32'h0000_7778, 4'h0));
    repeat (3) send_request(req_of(bbpm_pkg::KIND_RELEASE, 8'h00, 32'h0, 32'h0, 4'd3));
    send_request(req_of(bbpm_pkg::KIND_GET, 8'h33, 32'h0001_0000, 32'h0000_0001, 4'h0));
    send_request(req_of(bbpm_pkg::KIND_PIN, 8'h00, 32'h0, 32'h0, 4'd0));
  endtask

  task automatic test_count_saturation();
    repeat (256) send_request(req_of(bbpm_pkg::KIND_PIN, 8'h00, 32'h0, 32'h0, 4'd5));
    send_request(req_of(bbpm_pkg::KIND_GET, pool_file[5], pool_block[5], $urandom,
                        4'($urandom)));
    repeat (258) send_request(req_of(bbpm_pkg::KIND_RELEASE, 8'h00, 32'h0, 32'h0, 4'd5));
  endtask

  task automatic test_random_traffic(input int count);
    pool_req_t r;
    int pick;
    int held [$];
    repeat (count) begin
      r.file_id = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      r.block_num = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 9)) : $urandom;
      case ($urandom_range(0, 4))
        0, 1: r.file_blocks = r.block_num + 32'd1;
        2: r.file_blocks = r.block_num;
        3: r.file_blocks = $urandom;
        default: r.file_blocks = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      r.slot = 4'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) r.kind = bbpm_pkg::KIND_GET;
      else if (pick < 80) r.kind = bbpm_pkg::KIND_RELEASE;
      else if (pick < 87) r.kind = bbpm_pkg::KIND_PIN;
      else r.kind = bbpm_pkg::KIND_FLUSH;
      if (r.kind == bbpm_pkg::KIND_RELEASE && $urandom_range(0, 9) < 8) begin
        held.delete();
        for (int i = 0; i < SLOTS; i++) if (pool_refs[i] > 0) held.push_back(i);
        if (held.size() > 0) r.slot = 4'(held[$urandom_range(0, held.size() - 1)]);
      end
      send_request(r);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    pool_resp_t want;
    pool_resp_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.slot_out = out_tdata[3:0];
      got.read_needed = out_tdata[4];
      got.zero_fill = out_tdata[5];
      got.writeback = out_tdata[6];
      got.wb_file = out_tdata[14:7];
      got.wb_block = out_tdata[46:15];
      got.count_error = out_tdata[47];
      if (pending_responses.size() == 0) begin
        $error("unexpected transaction: status %0d slot %0d", got.status, got.slot_out);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.slot_out !== want.slot_out) begin
          $error("slot_out expected %0d actual %0d", want.slot_out, got.slot_out);
          fail_count++;
        end
        if (got.read_needed !== want.read_needed) begin
          $error("read_needed expected %0d actual %0d", want.read_needed, got.read_needed);
          fail_count++;
        end
        if (got.zero_fill !== want.zero_fill) begin
          $error("zero_fill expected %0d actual %0d", want.zero_fill, got.zero_fill);
          fail_count++;
        end
        if (got.writeback !== want.writeback) begin
          $error("writeback expected %0d actual %0d", want.writeback, got.writeback);
          fail_count++;
        end
        if (got.wb_file !== want.wb_file) begin
          $error("wb_file expected %0h actual %0h", want.wb_file, got.wb_file);
          fail_count++;
        end
        if (got.wb_block !== want.wb_block) begin
          $error("wb_block expected %0h actual %0h", want.wb_block, got.wb_block);
          fail_count++;
        end
        if (got.count_error !== want.count_error) begin
          $error("count_error expected %0d actual %0d", want.count_error, got.count_error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      pool_valid[i] = 1'b0;
      pool_file[i] = '0;
      pool_block[i] = '0;
      pool_refs[i] = '0;
      pool_dirty[i] = 1'b0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 59;
    test_fill_and_evict();
    test_random_traffic(100);
    send_idle_pct = 59;
    recv_idle_pct = 25;
    test_count_saturation();
    test_random_traffic(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(100);
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_responses.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bbpm_pkg.sv
hw/rtl/bbpm_store.sv
hw/rtl/block_buffer_pool_manager.sv
verif/tb.sv
